// ----- rtl/core/first_fit_heap_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator macros
// Assertion helpers shared by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define FFHA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define FFHA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared constants, types and helpers of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

	localparam int FREE_ENTRIES = 64;
	localparam int IDX_W        = $clog2(FREE_ENTRIES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int OFS_W        = 32;
	localparam int NEED_W       = OFS_W + 1;
	localparam int CHUNK_LOG2   = 22;
	localparam int KW           = NEED_W + 1 - CHUNK_LOG2;
	localparam int LIM_W        = 10;
	localparam int HDR_BYTES    = 8;
	localparam int MIN_SPLIT    = 24;
	localparam int LIMIT_RESET  = 256;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_ARG = 2'd1;
	localparam logic [1:0] STAT_LIMIT   = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [NEED_W-1:0] need;
		logic [OFS_W-1:0]  fa;
		logic [NEED_W-1:0] fa_end;
	} ffha_key_t;

	typedef struct packed {
		logic             pull_right;
		logic             pull_left;
		logic [IDX_W-1:0] idx;
	} ffha_op_t;

	typedef struct packed {
		logic fit;
		logic left_adj;
		logic right_adj;
	} ffha_flags_t;

	function automatic logic [IDX_W-1:0] onehot_index(input logic [FREE_ENTRIES-1:0] sel);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (sel[i]) begin
				r = r | IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ffha_cell.sv -----
// ---------------------------------------------------------------------------
// ffha_cell
// One free-table entry: holds start and length, compares against the
// current key and moves one place towards either neighbour on command.
// ---------------------------------------------------------------------------
module ffha_cell (
	input  logic                         clk,
	input  logic [ffha_pkg::IDX_W-1:0]   my_index,
	input  ffha_pkg::ffha_op_t           op,
	input  ffha_pkg::ffha_key_t          key,
	input  logic [ffha_pkg::OFS_W-1:0]   left_start,
	input  logic [ffha_pkg::OFS_W-1:0]   left_length,
	input  logic [ffha_pkg::OFS_W-1:0]   right_start,
	input  logic [ffha_pkg::OFS_W-1:0]   right_length,
	output logic [ffha_pkg::OFS_W-1:0]   start,
	output logic [ffha_pkg::OFS_W-1:0]   length,
	output ffha_pkg::ffha_flags_t        flags
);
	import ffha_pkg::*;

	logic [OFS_W-1:0] start_q;
	logic [OFS_W-1:0] len_q;
	logic [NEED_W-1:0] end_sum;

	always_ff @(posedge clk) begin
		if (op.pull_left) begin
			start_q <= left_start;
			len_q   <= left_length;
		end else if (op.pull_right && (my_index >= op.idx)) begin
			start_q <= right_start;
			len_q   <= right_length;
		end
	end

	assign end_sum         = {1'b0, start_q} + {1'b0, len_q};
	assign flags.fit       = {1'b0, len_q} >= key.need;
	assign flags.left_adj  = end_sum == {1'b0, key.fa};
	assign flags.right_adj = {1'b0, start_q} == key.fa_end;
	assign start           = start_q;
	assign length          = len_q;

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list allocator with coalescing, built on a chain of cells.
// ---------------------------------------------------------------------------
// Each request word gives one result word. The free table is a chain of 64
// cells that all compare against the request at once; a sequencer then
// picks the first match and edits the chain by moving entries one place at
// a time: remove, remove, insert at the head. Each item runs scan, pick,
// drop A, drop B, push and finish before the next word is accepted; finish
// waits while an earlier result is untaken, then loads the output register.
// A new word is accepted while an earlier result still waits at the output
// register. The limit register may be written at any time the block is idle.
module first_fit_heap_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [ffha_pkg::LIM_W-1:0]     cfg_write_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [ffha_pkg::OFS_W-1:0]     request_bytes,
	input  logic [ffha_pkg::OFS_W-1:0]     release_pointer,
	input  logic [ffha_pkg::OFS_W-1:0]     header_block_bytes,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     status,
	output logic [ffha_pkg::OFS_W-1:0]     user_offset,
	output logic [ffha_pkg::OFS_W-1:0]     granted_bytes
);
	import ffha_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_PICK   = 7'b0000100,
		ST_DROP_A = 7'b0001000,
		ST_DROP_B = 7'b0010000,
		ST_PUSH   = 7'b0100000,
		ST_FIN    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [LIM_W-1:0] limit_q;
	logic [LIM_W-1:0] chunks_q;
	logic [CNT_W-1:0] count_q;

	logic             act_q;
	logic             bad_q;
	ffha_key_t        key_q;
	logic [OFS_W-1:0] fsz_q;

	logic [FREE_ENTRIES-1:0] fit_q, lft_q, rgt_q;

	logic             drop_a_q, drop_b_q, push_q;
	logic [IDX_W-1:0] drop_a_idx_q, drop_b_idx_q;
	logic [OFS_W-1:0] push_start_q, push_len_q;
	logic [1:0]       res_status_q;
	logic [OFS_W-1:0] res_off_q, res_gr_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [OFS_W-1:0] user_offset_q, granted_q;

	ffha_op_t    op;
	ffha_flags_t cell_flags [FREE_ENTRIES];
	logic [OFS_W-1:0] cell_start [FREE_ENTRIES];
	logic [OFS_W-1:0] cell_len   [FREE_ENTRIES];

	// cell chain
	for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
		logic [OFS_W-1:0] l_start, l_len, r_start, r_len;
		if (i == 0) begin : g_head
			assign l_start = push_start_q;
			assign l_len   = push_len_q;
		end else begin : g_mid
			assign l_start = cell_start[i-1];
			assign l_len   = cell_len[i-1];
		end
		if (i == FREE_ENTRIES - 1) begin : g_tail
			assign r_start = '0;
			assign r_len   = '0;
		end else begin : g_body
			assign r_start = cell_start[i+1];
			assign r_len   = cell_len[i+1];
		end
		ffha_cell u_cell (
			.clk          (clk),
			.my_index     (IDX_W'(i)),
			.op           (op),
			.key          (key_q),
			.left_start   (l_start),
			.left_length  (l_len),
			.right_start  (r_start),
			.right_length (r_len),
			.start        (cell_start[i]),
			.length       (cell_len[i]),
			.flags        (cell_flags[i])
		);
	end

	always_comb begin
		op = '0;
		unique case (state_q)
			ST_DROP_A: begin
				op.pull_right = drop_a_q;
				op.idx        = drop_a_idx_q;
			end
			ST_DROP_B: begin
				op.pull_right = drop_b_q;
				op.idx        = drop_b_idx_q;
			end
			ST_PUSH: begin
				op.pull_left = push_q;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	// decision on registered match flags
	logic [FREE_ENTRIES-1:0] fit_sel, lft_sel, rgt_el, rgt_sel;
	logic [OFS_W-1:0]        fit_start, fit_len, ls, ll, rl;
	logic [IDX_W-1:0]        fit_idx, l_idx, r_idx;
	logic                    hl, hr;
	logic [NEED_W-1:0]       rem;
	logic [KW-1:0]           k;
	logic [KW:0]             total;
	logic [KW+CHUNK_LOG2-1:0] span, spare;
	logic [OFS_W-1:0]        base;
	logic                    full;

	logic             n_drop_a, n_drop_b, n_push, n_grow;
	logic [IDX_W-1:0] n_a_idx, n_b_idx;
	logic [OFS_W-1:0] n_p_start, n_p_len;
	logic [1:0]       n_status;
	logic [OFS_W-1:0] n_off, n_gr;

	always_comb begin
		fit_sel   = fit_q & (~fit_q + FREE_ENTRIES'(1));
		lft_sel   = lft_q & (~lft_q + FREE_ENTRIES'(1));
		rgt_el    = rgt_q & ~lft_sel;
		rgt_sel   = rgt_el & (~rgt_el + FREE_ENTRIES'(1));
		fit_start = '0;
		fit_len   = '0;
		ls        = '0;
		ll        = '0;
		rl        = '0;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (fit_sel[i]) begin
				fit_start = fit_start | cell_start[i];
				fit_len   = fit_len | cell_len[i];
			end
			if (lft_sel[i]) begin
				ls = ls | cell_start[i];
				ll = ll | cell_len[i];
			end
			if (rgt_sel[i]) begin
				rl = rl | cell_len[i];
			end
		end
		fit_idx = onehot_index(fit_sel);
		l_idx   = onehot_index(lft_sel);
		r_idx   = onehot_index(rgt_sel);
		hl      = |lft_q;
		hr      = |rgt_el;

		rem   = {1'b0, fit_len} - key_q.need;
		k     = KW'(({1'b0, key_q.need} + (NEED_W+1)'((1 << CHUNK_LOG2) - 1)) >> CHUNK_LOG2);
		total = (KW+1)'(chunks_q) + (KW+1)'(k);
		span  = {k, {CHUNK_LOG2{1'b0}}};
		spare = span - (KW+CHUNK_LOG2)'(key_q.need);
		base  = OFS_W'({chunks_q, {CHUNK_LOG2{1'b0}}});
		full  = count_q == CNT_W'(FREE_ENTRIES);

		n_drop_a  = 1'b0;
		n_drop_b  = 1'b0;
		n_push    = 1'b0;
		n_grow    = 1'b0;
		n_a_idx   = '0;
		n_b_idx   = '0;
		n_p_start = '0;
		n_p_len   = '0;
		n_status  = STAT_OK;
		n_off     = '0;
		n_gr      = '0;

		if (bad_q) begin
			n_status = STAT_BAD_ARG;
		end else if (!act_q) begin
			if (|fit_q) begin
				n_drop_a = 1'b1;
				n_a_idx  = fit_idx;
				n_off    = fit_start + OFS_W'(HDR_BYTES);
				if (rem >= NEED_W'(MIN_SPLIT)) begin
					n_push    = 1'b1;
					n_p_start = fit_start + key_q.need[OFS_W-1:0];
					n_p_len   = rem[OFS_W-1:0];
					n_gr      = key_q.need[OFS_W-1:0];
				end else begin
					n_gr = fit_len;
				end
			end else if (total > (KW+1)'(limit_q)) begin
				n_status = STAT_LIMIT;
			end else if (spare >= (KW+CHUNK_LOG2)'(MIN_SPLIT)) begin
				if (full) begin
					n_status = STAT_FULL;
				end else begin
					n_grow    = 1'b1;
					n_push    = 1'b1;
					n_p_start = base + key_q.need[OFS_W-1:0];
					n_p_len   = spare[OFS_W-1:0];
					n_gr      = key_q.need[OFS_W-1:0];
					n_off     = base + OFS_W'(HDR_BYTES);
				end
			end else begin
				n_grow = 1'b1;
				n_gr   = span[OFS_W-1:0];
				n_off  = base + OFS_W'(HDR_BYTES);
			end
		end else begin
			n_push  = 1'b1;
			n_p_len = (hl ? ll : '0) + fsz_q + (hr ? rl : '0);
			n_p_start = hl ? ls : key_q.fa;
			if (hl && hr) begin
				// drop the deeper entry first so the other index stays put
				n_drop_a = 1'b1;
				n_drop_b = 1'b1;
				n_a_idx  = (l_idx > r_idx) ? l_idx : r_idx;
				n_b_idx  = (l_idx > r_idx) ? r_idx : l_idx;
			end else if (hl) begin
				n_drop_a = 1'b1;
				n_a_idx  = l_idx;
			end else if (hr) begin
				n_drop_a = 1'b1;
				n_a_idx  = r_idx;
			end else if (full) begin
				n_push   = 1'b0;
				n_status = STAT_FULL;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   state_d = ST_PICK;
			ST_PICK:   state_d = ST_DROP_A;
			ST_DROP_A: state_d = ST_DROP_B;
			ST_DROP_B: state_d = ST_PUSH;
			ST_PUSH:   state_d = ST_FIN;
			ST_FIN:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIM_W'(LIMIT_RESET);
			chunks_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			drop_a_q    <= 1'b0;
			drop_b_q    <= 1'b0;
			push_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (state_q == ST_PICK) begin
				drop_a_q <= n_drop_a;
				drop_b_q <= n_drop_b;
				push_q   <= n_push;
				if (n_grow) begin
					chunks_q <= chunks_q + k[LIM_W-1:0];
				end
			end
			if ((state_q == ST_DROP_A && drop_a_q) || (state_q == ST_DROP_B && drop_b_q)) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (state_q == ST_PUSH && push_q) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q            <= action;
			fsz_q            <= header_block_bytes;
			key_q.need       <= ({1'b0, request_bytes} + NEED_W'(HDR_BYTES + 7))
				& ~NEED_W'(7);
			key_q.fa         <= release_pointer - OFS_W'(HDR_BYTES);
			key_q.fa_end     <= {1'b0, release_pointer - OFS_W'(HDR_BYTES)}
				+ {1'b0, header_block_bytes};
			bad_q            <= action ? (release_pointer < OFS_W'(HDR_BYTES)
				|| header_block_bytes == '0) : (request_bytes == '0);
		end
		if (state_q == ST_SCAN) begin
			for (int i = 0; i < FREE_ENTRIES; i++) begin
				fit_q[i] <= cell_flags[i].fit && (CNT_W'(i) < count_q);
				lft_q[i] <= cell_flags[i].left_adj && (CNT_W'(i) < count_q);
				rgt_q[i] <= cell_flags[i].right_adj && (CNT_W'(i) < count_q);
			end
		end
		if (state_q == ST_PICK) begin
			drop_a_idx_q <= n_a_idx;
			drop_b_idx_q <= n_b_idx;
			push_start_q <= n_p_start;
			push_len_q   <= n_p_len;
			res_status_q <= n_status;
			res_off_q    <= n_off;
			res_gr_q     <= n_gr;
		end
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			status_q      <= res_status_q;
			user_offset_q <= res_off_q;
			granted_q     <= res_gr_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign user_offset   = user_offset_q;
	assign granted_bytes = granted_q;

`include "first_fit_heap_allocator_macros.svh"

	`FFHA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(FREE_ENTRIES), "free table overfilled")
	`FFHA_ASSERT_NOW(a_push_room, state_q == ST_PUSH && push_q, count_q < CNT_W'(FREE_ENTRIES), "head insert into full table")
	`FFHA_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_q == ST_SCAN, "accepted word not scanned")
	`FFHA_ASSERT_NEXT(a_fin_out, state_q == ST_FIN && (!out_valid_q || out_ready), out_valid_q, "finished result not presented")

endmodule
